FILE: rtl/core/qdo_pkg.sv
// ----------------------------------------------------------------------------
// qdo_pkg
// Shared types, constants and the arctangent table for the odometry core.
// ----------------------------------------------------------------------------
package qdo_pkg;

    localparam int CordicSteps = 24;
    localparam int StepW       = $clog2(CordicSteps + 1);
    localparam logic signed [35:0] CordicGain = 36'sd652032874;
    localparam logic [50:0] TermLimit = 51'h4_0000_0000_0000;

    typedef enum logic [1:0] {
        KIND_EDGE   = 2'd0,
        KIND_UPDATE = 2'd1,
        KIND_SPEED  = 2'd2,
        KIND_RESET  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_RIGHT_DPT   = 3'd0,
        REG_LEFT_DPT    = 3'd1,
        REG_RIGHT_REV   = 3'd2,
        REG_LEFT_REV    = 3'd3,
        REG_ANGLE_PER_D = 3'd4,
        REG_HALF_SPACE  = 3'd5,
        REG_SPEED_SCALE = 3'd6
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST_R,
        ST_DIST_L,
        ST_CORDIC_START,
        ST_CORDIC,
        ST_POS_X,
        ST_POS_Y,
        ST_ANGLE,
        ST_SPD_R,
        ST_SPD_L,
        ST_SPD_W,
        ST_SPD_T,
        ST_SPD_H,
        ST_SPD_OUT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } cordic_ctl_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > 64'sd2147483647)
            r = 64'sd2147483647;
        else if (v < -64'sd2147483648)
            r = -64'sd2147483648;
        else
            r = v;
        return r;
    endfunction

endpackage

FILE: rtl/core/qdo_cordic.sv
// ----------------------------------------------------------------------------
// qdo_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, cos and sin in Q30.
// ----------------------------------------------------------------------------
module qdo_cordic (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [31:0]            angle,
    output qdo_pkg::cordic_ctl_t   ctl,
    output logic signed [35:0]     cos_val,
    output logic signed [35:0]     sin_val
);
    import qdo_pkg::*;

    logic signed [35:0] x_reg, x_next, y_reg, y_next;
    logic signed [32:0] z_reg, z_next;
    logic [StepW-1:0]   step_reg, step_next;
    logic               busy_reg, busy_next, flip_reg, flip_next, done_reg, done_next;
    logic [31:0]        ang_rot;
    logic signed [35:0] dx, dy;
    logic signed [32:0] at;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        flip_next = flip_reg;
        done_next = 1'b0;
        ang_rot   = angle;
        dx        = y_reg >>> step_reg;
        dy        = x_reg >>> step_reg;
        at        = {1'b0, atan_entry(5'(step_reg))};
        if (start)
        begin
            flip_next = angle[31] ^ angle[30];
            if (flip_next)
                ang_rot = angle + 32'h8000_0000;
            x_next    = CordicGain;
            y_next    = '0;
            z_next    = {ang_rot[31], ang_rot};
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[32])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            step_next = step_reg + 1'b1;
            if (step_reg == StepW'(CordicSteps - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign cos_val   = flip_reg ? -x_reg : x_reg;
    assign sin_val   = flip_reg ? -y_reg : y_reg;

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.done |-> $past(busy_reg)) else $error("cordic done without run");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start) else $error("cordic restarted while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("cordic done held");
`endif

endmodule

FILE: rtl/core/quadrature_differential_odometry_top.sv
// ----------------------------------------------------------------------------
// quadrature_differential_odometry_top
// Dead-reckoning odometry with two quadrature encoders and CORDIC heading.
// ----------------------------------------------------------------------------
// Pin edges and pose resets pass through ST_OUT to result valid; an update tick
// runs 24 CORDIC steps on the rotator plus one multiply per cycle, and a speed
// period end runs its chain of multiplies, all from accept to result valid.
// Throughput: one item at a time; s_tready is low until the result is taken.
// Reset: rst_n asynchronous, clears pose, counters, sums and restores defaults.
module quadrature_differential_odometry_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // side, channel, level_a, level_b, zero
    input  logic [1:0]   s_tuser,    // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,    // x, y, heading, right speed, left speed
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import qdo_pkg::*;

    logic [31:0] rdpt_reg, ldpt_reg, apd_reg, hsa_reg;
    logic        rrev_reg, lrev_reg;
    logic [15:0] sscale_reg;
    logic [15:0] rcnt_reg, rcnt_next, lcnt_reg, lcnt_next, rlast_reg, rlast_next;
    logic [15:0] llast_reg, llast_next;
    logic [31:0] x_reg, x_next, y_reg, y_next, hd_reg, hd_next;
    logic [31:0] rsum_reg, rsum_next, lsum_reg, lsum_next, asum_reg, asum_next;
    logic [31:0] rspd_reg, rspd_next, lspd_reg, lspd_next;
    logic signed [63:0] dr_reg, dr_next, dl_reg, dl_next, acc_reg, acc_next;
    logic signed [63:0] t_reg, t_next;
    state_t      state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        cstart;
    cordic_ctl_t cctl;
    logic signed [35:0] cosv, sinv;

    logic signed [32:0] ma;
    logic signed [35:0] mb;
    logic signed [68:0] prod;
    logic [15:0]  cur, dif;
    logic         up;
    logic signed [63:0] dc, dd, mean, sum;
    logic [63:0]  mag, p64, hb, sp;
    logic         neg;
    logic [31:0]  q;
    logic [50:0]  tcl;

    assign s_tready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {lspd_reg, rspd_reg, hd_reg, y_reg, x_reg};

    qdo_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cstart),
        .angle   (hd_reg),
        .ctl     (cctl),
        .cos_val (cosv),
        .sin_val (sinv)
    );

    assign prod = ma * mb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdpt_reg   <= 32'd65536;
            ldpt_reg   <= 32'd65536;
            rrev_reg   <= 1'b0;
            lrev_reg   <= 1'b0;
            apd_reg    <= 32'd65536;
            hsa_reg    <= 32'd65536;
            sscale_reg <= 16'd100;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_RIGHT_DPT:   rdpt_reg   <= cfg_data;
                REG_LEFT_DPT:    ldpt_reg   <= cfg_data;
                REG_RIGHT_REV:   rrev_reg   <= cfg_data[0];
                REG_LEFT_REV:    lrev_reg   <= cfg_data[0];
                REG_ANGLE_PER_D: apd_reg    <= cfg_data;
                REG_HALF_SPACE:  hsa_reg    <= cfg_data;
                REG_SPEED_SCALE: sscale_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        rcnt_next = rcnt_reg;   lcnt_next = lcnt_reg;
        rlast_next = rlast_reg; llast_next = llast_reg;
        x_next = x_reg; y_next = y_reg; hd_next = hd_reg;
        rsum_next = rsum_reg; lsum_next = lsum_reg; asum_next = asum_reg;
        rspd_next = rspd_reg; lspd_next = lspd_reg;
        dr_next = dr_reg; dl_next = dl_reg; acc_next = acc_reg; t_next = t_reg;
        cstart = 1'b0;
        ma = '0;
        mb = '0;
        cur = '0;
        dif = '0;
        up = 1'b0;
        dc = (dr_reg + dl_reg) >>> 1;
        dd = dr_reg - dl_reg;
        mean = '0;
        sum = '0;
        neg = 1'b0;
        mag = '0;
        p64 = '0;
        hb = '0;
        sp = '0;
        q = '0;
        tcl = '0;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    case (kind_t'(s_tuser))
                        KIND_EDGE:
                        begin
                            up = s_tdata[1] ? (s_tdata[2] == s_tdata[3])
                                            : (s_tdata[2] != s_tdata[3]);
                            if (s_tdata[0])
                                rcnt_next = !up ? rcnt_reg + 16'd1 : rcnt_reg - 16'd1;
                            else
                                lcnt_next = up ? lcnt_reg + 16'd1 : lcnt_reg - 16'd1;
                            state_next = ST_OUT;
                        end
                        KIND_UPDATE: state_next = ST_DIST_R;
                        KIND_SPEED:  state_next = ST_SPD_R;
                        default:
                        begin
                            x_next = '0;
                            y_next = '0;
                            hd_next = '0;
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_DIST_R:
            begin
                cur = rrev_reg ? 16'd0 - rcnt_reg : rcnt_reg;
                dif = cur - rlast_reg;
                rlast_next = cur;
                ma = 33'(signed'(dif));
                mb = {4'd0, rdpt_reg};
                dr_next = sat32(64'(prod));
                state_next = ST_DIST_L;
            end
            ST_DIST_L:
            begin
                cur = lrev_reg ? 16'd0 - lcnt_reg : lcnt_reg;
                dif = cur - llast_reg;
                llast_next = cur;
                ma = 33'(signed'(dif));
                mb = {4'd0, ldpt_reg};
                dl_next = sat32(64'(prod));
                state_next = ST_CORDIC_START;
            end
            ST_CORDIC_START:
            begin
                cstart = 1'b1;
                state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                if (cctl.done)
                    state_next = ST_POS_X;
            end
            ST_POS_X:
            begin
                ma = dc[32:0];
                mb = cosv;
                x_next = x_reg + 32'(prod >>> 30);
                state_next = ST_POS_Y;
            end
            ST_POS_Y:
            begin
                ma = dc[32:0];
                mb = sinv;
                y_next = y_reg + 32'(prod >>> 30);
                state_next = ST_ANGLE;
            end
            ST_ANGLE:
            begin
                neg = dd[63];
                mag = neg ? 64'(-dd) : 64'(dd);
                ma = {1'b0, mag[31:0]};
                mb = {4'd0, apd_reg};
                p64 = prod[63:0];
                q = p64[63:32];
                if (neg && (p64[31:0] != 32'd0))
                    q = q + 32'd1;
                if (neg)
                    q = 32'd0 - q;
                hd_next = hd_reg + q;
                asum_next = asum_reg + q;
                rsum_next = rsum_reg + dr_reg[31:0];
                lsum_next = lsum_reg + dl_reg[31:0];
                state_next = ST_OUT;
            end
            ST_SPD_R:
            begin
                ma = {rsum_reg[31], rsum_reg};
                mb = {20'd0, sscale_reg};
                dr_next = 64'(prod);
                state_next = ST_SPD_L;
            end
            ST_SPD_L:
            begin
                ma = {lsum_reg[31], lsum_reg};
                mb = {20'd0, sscale_reg};
                dl_next = 64'(prod);
                state_next = ST_SPD_W;
            end
            ST_SPD_W:
            begin
                ma = {asum_reg[31], asum_reg};
                mb = {20'd0, sscale_reg};
                acc_next = 64'(prod);
                state_next = ST_SPD_T;
            end
            ST_SPD_T:
            begin
                neg = acc_reg[63];
                mag = neg ? 64'(-acc_reg) : 64'(acc_reg);
                ma = {1'b0, mag[31:0]};
                mb = {4'd0, hsa_reg};
                t_next = 64'(prod);
                state_next = ST_SPD_H;
            end
            ST_SPD_H:
            begin
                neg = acc_reg[63];
                mag = neg ? 64'(-acc_reg) : 64'(acc_reg);
                ma = {17'd0, mag[47:32]};
                mb = {4'd0, hsa_reg};
                hb = prod[63:0];
                p64 = t_reg;
                if (((hb >> 18) != 64'd0) || (p64 >= 64'(TermLimit)))
                    tcl = TermLimit;
                else
                begin
                    sp = (hb << 32) + p64;
                    tcl = (sp > 64'(TermLimit)) ? TermLimit : sp[50:0];
                end
                t_next = neg ? -64'(tcl) : 64'(tcl);
                state_next = ST_SPD_OUT;
            end
            ST_SPD_OUT:
            begin
                sum = dr_reg + dl_reg;
                mean = sum >>> 1;
                rspd_next = 32'(sat32(mean + t_reg));
                lspd_next = 32'(sat32(mean - t_reg));
                rsum_next = '0;
                lsum_next = '0;
                asum_next = '0;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rcnt_reg <= '0; lcnt_reg <= '0; rlast_reg <= '0; llast_reg <= '0;
            x_reg <= '0; y_reg <= '0; hd_reg <= '0;
            rsum_reg <= '0; lsum_reg <= '0; asum_reg <= '0;
            rspd_reg <= '0; lspd_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            rcnt_reg <= rcnt_next; lcnt_reg <= lcnt_next;
            rlast_reg <= rlast_next; llast_reg <= llast_next;
            x_reg <= x_next; y_reg <= y_next; hd_reg <= hd_next;
            rsum_reg <= rsum_next; lsum_reg <= lsum_next; asum_reg <= asum_next;
            rspd_reg <= rspd_next; lspd_reg <= lspd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dr_reg  <= dr_next;
        dl_reg  <= dl_next;
        acc_reg <= acc_next;
        t_reg   <= t_next;
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("accepted while busy");
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result moved");
    a_cordic_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cctl.busy |-> (state_reg == ST_CORDIC)) else $error("cordic out of step");
`endif

endmodule
